// File: src/clpu_pkg.sv
package clpu_pkg;

  // Fixed field widths
  localparam int COORD_W    = 32;
  localparam int RADIUS_W   = 32;
  localparam int RELAX_W    = 17;
  localparam int RELAX_SH   = 16;
  localparam int SQ_W       = 64;
  localparam int CMD_W      = 3;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = 66;
  localparam int SQRT_VW    = 68;
  localparam int ROOT_W     = SQRT_VW / 2;
  localparam int LEN_W      = 33;
  localparam int DIFF_W     = 34;
  localparam int RPROD_W    = DIFF_W + RELAX_W + 1;

  localparam int DEF_MAX_NEIGHBORS = 64;

  // Register reset values
  localparam logic [RELAX_W-1:0]  RELAX_RESET = 17'd655;
  localparam logic [RADIUS_W-1:0] DIST_RESET  = 32'd66;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_ORIG = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_CUR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_NB    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLR_MAX   = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RELAX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_ORIG,
    OP_LOAD_CUR,
    OP_ADD_NB,
    OP_CLR_MAX,
    OP_AVG_START,
    OP_AVG_SAVE,
    OP_RELAX_MUL,
    OP_STEP,
    OP_DIFF_ORIG,
    OP_DIFF_CUR,
    OP_SQ_MUL,
    OP_ACC_ADD,
    OP_SQRT_LIM,
    OP_SAVE_R,
    OP_SQRT_LEN,
    OP_SAVE_LEN,
    OP_SCALE_MUL,
    OP_SCALE_DIV,
    OP_CLAMP_SET,
    OP_FIN_PIN,
    OP_FIN_OUT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_PIN,
    S_AVG_START,
    S_AVG_WAIT,
    S_AVG_SAVE,
    S_RELAX,
    S_STEP,
    S_D2_DIFF,
    S_D2_MUL,
    S_D2_ACC,
    S_D2_CMP,
    S_SQ_LIM,
    S_SQ_LIM_WAIT,
    S_SQ_LEN,
    S_SQ_LEN_WAIT,
    S_CL_DIFF,
    S_CL_MUL,
    S_CL_DIV,
    S_CL_WAIT,
    S_CL_SET,
    S_MV_DIFF,
    S_MV_MUL,
    S_MV_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } ctl_t;

  typedef struct packed {
    logic count_zero;
    logic lim_zero;
    logic lim_ones;
    logic in_limit;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

// File: src/constrained_laplacian_point_update.sv
// Load, add-neighbor and clear commands are taken while idle and do not raise the stall.
// A finish with an empty stencil or a zero limit pins the point; otherwise it runs three serial
// average divides plus the squared-offset pass unless the limit is all ones, and with
// clamping two square roots and three more divides, before the moved-distance pass.
// One divider and one square-root unit are shared, one item is in work at a time.
// Synchronous reset loads the register defaults and clears the stored positions, sums, count, limit and maximum.
module constrained_laplacian_point_update import clpu_pkg::*; #(
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     command,
  input  logic [COORD_W-1:0]   coord_x,
  input  logic [COORD_W-1:0]   coord_y,
  input  logic [COORD_W-1:0]   coord_z,
  input  logic [RADIUS_W-1:0]  point_constraint,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   new_x,
  output logic [COORD_W-1:0]   new_y,
  output logic [COORD_W-1:0]   new_z,
  output logic [SQ_W-1:0]      moved_sq,
  output logic [SQ_W-1:0]      max_moved_sq,
  output logic                 pinned,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  clpu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .command(command),
    .stat(stat), .in_stall(in_stall), .ctl(ctl)
  );

  clpu_dp #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .point_constraint(point_constraint),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_x(new_x), .new_y(new_y), .new_z(new_z),
    .moved_sq(moved_sq), .max_moved_sq(max_moved_sq), .pinned(pinned)
  );

endmodule

// File: src/clpu_div.sv
module clpu_div import clpu_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic          done
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      sh;
  logic             fits;
  logic [DW:0]      sub;

  // one quotient bit per cycle, restoring
  always_comb begin
    sh   = {rem_r, quo_r[NW-1]};
    fits = (sh >= {1'b0, den_r});
    sub  = sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      quo_r <= {quo_r[NW-2:0], fits};
      rem_r <= fits ? sub[DW-1:0] : sh[DW-1:0];
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

// File: src/clpu_sqrt.sv
module clpu_sqrt import clpu_pkg::*; #(
  parameter int VW = 68
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [VW-1:0]   value,
  output logic [VW/2-1:0] root,
  output logic            done
);

  localparam int H     = VW / 2;
  localparam int CNT_W = $clog2(H + 1);

  logic [VW-1:0]    val_r;
  logic [H-1:0]     root_r;
  logic [H+1:0]     rem_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [H+3:0]     rem_t;
  logic [H+3:0]     trial;
  logic             fits;
  logic [H+3:0]     sub;

  // one root bit per cycle, two value bits shifted in
  always_comb begin
    rem_t = {rem_r, val_r[VW-1:VW-2]};
    trial = {2'b00, root_r, 2'b01};
    fits  = (rem_t >= trial);
    sub   = rem_t - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(H);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy) begin
      val_r  <= {val_r[VW-3:0], 2'b00};
      root_r <= {root_r[H-2:0], fits};
      rem_r  <= fits ? sub[H+1:0] : rem_t[H+1:0];
    end
  end

  assign root = root_r;

endmodule

// File: src/clpu_ctrl.sv
module clpu_ctrl import clpu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  input  stat_t            stat,
  output logic             in_stall,
  output ctl_t             ctl
);

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // command dispatch while idle and sequencing of one finish through the datapath
  always_comb begin
    state_next = state;
    idx_next   = idx;
    ctl.op     = OP_NONE;
    ctl.idx    = idx;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (command)
            CMD_LOAD_ORIG: ctl.op = OP_LOAD_ORIG;
            CMD_LOAD_CUR:  ctl.op = OP_LOAD_CUR;
            CMD_ADD_NB:    ctl.op = OP_ADD_NB;
            CMD_CLR_MAX:   ctl.op = OP_CLR_MAX;
            CMD_FINISH:    state_next = S_CHECK;
            default:       ctl.op = OP_NONE;
          endcase
        end
      end
      S_CHECK: begin
        idx_next = '0;
        if (stat.count_zero || stat.lim_zero) state_next = S_PIN;
        else                                  state_next = S_AVG_START;
      end
      S_PIN: begin
        if (stat.out_free) begin
          ctl.op     = OP_FIN_PIN;
          state_next = S_IDLE;
        end
      end
      S_AVG_START: begin
        ctl.op     = OP_AVG_START;
        state_next = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (stat.div_done) state_next = S_AVG_SAVE;
      end
      S_AVG_SAVE: begin
        ctl.op     = OP_AVG_SAVE;
        state_next = S_RELAX;
      end
      S_RELAX: begin
        ctl.op     = OP_RELAX_MUL;
        state_next = S_STEP;
      end
      S_STEP: begin
        ctl.op = OP_STEP;
        if (idx == 2'd2) begin
          idx_next   = '0;
          state_next = stat.lim_ones ? S_MV_DIFF : S_D2_DIFF;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_AVG_START;
        end
      end
      S_D2_DIFF: begin
        ctl.op     = OP_DIFF_ORIG;
        state_next = S_D2_MUL;
      end
      S_D2_MUL: begin
        ctl.op     = OP_SQ_MUL;
        state_next = S_D2_ACC;
      end
      S_D2_ACC: begin
        ctl.op = OP_ACC_ADD;
        if (idx == 2'd2) begin
          idx_next   = '0;
          state_next = S_D2_CMP;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_D2_DIFF;
        end
      end
      S_D2_CMP: begin
        state_next = stat.in_limit ? S_MV_DIFF : S_SQ_LIM;
      end
      S_SQ_LIM: begin
        ctl.op     = OP_SQRT_LIM;
        state_next = S_SQ_LIM_WAIT;
      end
      S_SQ_LIM_WAIT: begin
        if (stat.sqrt_done) begin
          ctl.op     = OP_SAVE_R;
          state_next = S_SQ_LEN;
        end
      end
      S_SQ_LEN: begin
        ctl.op     = OP_SQRT_LEN;
        state_next = S_SQ_LEN_WAIT;
      end
      S_SQ_LEN_WAIT: begin
        if (stat.sqrt_done) begin
          ctl.op     = OP_SAVE_LEN;
          state_next = S_CL_DIFF;
        end
      end
      S_CL_DIFF: begin
        ctl.op     = OP_DIFF_ORIG;
        state_next = S_CL_MUL;
      end
      S_CL_MUL: begin
        ctl.op     = OP_SCALE_MUL;
        state_next = S_CL_DIV;
      end
      S_CL_DIV: begin
        ctl.op     = OP_SCALE_DIV;
        state_next = S_CL_WAIT;
      end
      S_CL_WAIT: begin
        if (stat.div_done) state_next = S_CL_SET;
      end
      S_CL_SET: begin
        ctl.op = OP_CLAMP_SET;
        if (idx == 2'd2) begin
          idx_next   = '0;
          state_next = S_MV_DIFF;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_CL_DIFF;
        end
      end
      S_MV_DIFF: begin
        ctl.op     = OP_DIFF_CUR;
        state_next = S_MV_MUL;
      end
      S_MV_MUL: begin
        ctl.op     = OP_SQ_MUL;
        state_next = S_MV_ACC;
      end
      S_MV_ACC: begin
        ctl.op = OP_ACC_ADD;
        if (idx == 2'd2) begin
          idx_next   = '0;
          state_next = S_OUT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_MV_DIFF;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.op     = OP_FIN_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/clpu_dp.sv
module clpu_dp import clpu_pkg::*; #(
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  output stat_t                stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [COORD_W-1:0]   coord_x,
  input  logic [COORD_W-1:0]   coord_y,
  input  logic [COORD_W-1:0]   coord_z,
  input  logic [RADIUS_W-1:0]  point_constraint,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   new_x,
  output logic [COORD_W-1:0]   new_y,
  output logic [COORD_W-1:0]   new_z,
  output logic [SQ_W-1:0]      moved_sq,
  output logic [SQ_W-1:0]      max_moved_sq,
  output logic                 pinned
);

  localparam int CW     = $clog2(MAX_NEIGHBORS + 1);
  localparam int SW     = COORD_W + CW;
  localparam int AVG_NW = SW + 2;
  localparam int DIV_NW = (AVG_NW > SQ_W) ? AVG_NW : SQ_W;
  localparam int DIV_DW = ((CW + 1) > LEN_W) ? (CW + 1) : LEN_W;

  // configuration
  logic [RELAX_W-1:0]  relax;
  logic [RADIUS_W-1:0] cons_dist;
  logic                source;

  // point state
  logic [COORD_W-1:0]   orig [3];
  logic [COORD_W-1:0]   cur  [3];
  logic [COORD_W-1:0]   xpos [3];
  logic signed [SW-1:0] nsum [3];
  logic [CW-1:0]        count;
  logic [SQ_W-1:0]      limit;
  logic [SQ_W-1:0]      run_max;

  // working registers
  logic                        avg_neg;
  logic signed [DIFF_W-1:0]    diff_reg;
  logic signed [RPROD_W-1:0]   relax_prod;
  logic [COORD_W-1:0]          mag_reg;
  logic                        neg_reg;
  logic [SQ_W-1:0]             prod_reg;
  logic [ACC_W-1:0]            acc;
  logic [COORD_W-1:0]          r_reg;
  logic [LEN_W-1:0]            len_reg;

  logic [COORD_W-1:0] in_pos [3];
  assign in_pos[0] = coord_x;
  assign in_pos[1] = coord_y;
  assign in_pos[2] = coord_z;

  // units
  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] div_quo;
  logic [DIV_DW-1:0] div_rem;
  logic              div_done;
  logic              sqrt_start;
  logic [SQRT_VW-1:0] sqrt_val;
  logic [ROOT_W-1:0] sqrt_root;
  logic              sqrt_done;

  clpu_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .rem(div_rem), .done(div_done)
  );

  clpu_sqrt #(.VW(SQRT_VW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .value(sqrt_val),
    .root(sqrt_root), .done(sqrt_done)
  );

  // combinational helpers
  logic signed [SW-1:0]     sum_sel;
  logic signed [AVG_NW-1:0] avg_num;
  logic [AVG_NW-1:0]        avg_mag;
  logic [32:0]              q33;
  logic [32:0]              qr;
  logic [32:0]              avg;
  logic [RPROD_W-1:0]       step_full;
  logic [35:0]              step;
  logic [36:0]              vsum;
  logic [COORD_W-1:0]       vsat;
  logic [COORD_W-1:0]       diff_ref;
  logic [32:0]              dsub;
  logic [COORD_W-1:0]       dmag;
  logic [RADIUS_W-1:0]      r_sel;
  logic [COORD_W-1:0]       mul_a;
  logic [COORD_W-1:0]       mul_b;
  logic [SQ_W-1:0]          mul_p;
  logic [SQ_W-1:0]          moved;
  logic [COORD_W-1:0]       qv;
  logic                     out_free;

  always_comb begin
    // average numerator 2*sum + n and its magnitude
    sum_sel = nsum[ctl.idx];
    avg_num = {sum_sel[SW-1], sum_sel, 1'b0} + AVG_NW'(count);
    avg_mag = avg_num[AVG_NW-1] ? (~avg_num + 1'b1) : avg_num;
    // floor division fix for a negative numerator
    q33 = div_quo[32:0];
    qr  = q33 + 33'(div_rem != '0);
    avg = avg_neg ? (~qr + 1'b1) : q33;
    // rounded relaxation step and saturation
    step_full = relax_prod + RPROD_W'(32768);
    step      = step_full[RPROD_W-1:RELAX_SH];
    vsum      = {{5{cur[ctl.idx][31]}}, cur[ctl.idx]} + {step[35], step};
    if (vsum[36:31] == 6'b000000 || vsum[36:31] == 6'b111111)
      vsat = vsum[31:0];
    else
      vsat = vsum[36] ? 32'h8000_0000 : 32'h7fff_ffff;
    // offset magnitude against original or current position
    diff_ref = (ctl.op == OP_DIFF_CUR) ? cur[ctl.idx] : orig[ctl.idx];
    dsub     = {xpos[ctl.idx][31], xpos[ctl.idx]} - {diff_ref[31], diff_ref};
    dmag     = dsub[32] ? 32'(~dsub + 1'b1) : dsub[31:0];
    // shared multiplier
    r_sel = source ? point_constraint : cons_dist;
    mul_a = mag_reg;
    mul_b = mag_reg;
    if (ctl.op == OP_LOAD_ORIG) begin
      mul_a = r_sel;
      mul_b = r_sel;
    end else if (ctl.op == OP_SCALE_MUL) begin
      mul_b = r_reg;
    end
    mul_p = mul_a * mul_b;
    moved = (acc[ACC_W-1:SQ_W] != '0) ? '1 : acc[SQ_W-1:0];
    qv    = div_quo[COORD_W-1:0];
    // unit starts
    div_start  = (ctl.op == OP_AVG_START) || (ctl.op == OP_SCALE_DIV);
    div_num    = (ctl.op == OP_AVG_START) ? DIV_NW'(avg_mag) : DIV_NW'(prod_reg);
    div_den    = (ctl.op == OP_AVG_START) ? DIV_DW'({count, 1'b0}) : DIV_DW'(len_reg);
    sqrt_start = (ctl.op == OP_SQRT_LIM) || (ctl.op == OP_SQRT_LEN);
    sqrt_val   = (ctl.op == OP_SQRT_LIM) ? SQRT_VW'(limit) : SQRT_VW'(acc);
    out_free   = !out_valid || !out_stall;
  end

  // status to the controller
  always_comb begin
    stat.count_zero = (count == '0);
    stat.lim_zero   = (limit == '0);
    stat.lim_ones   = (limit == '1);
    stat.in_limit   = (acc <= ACC_W'(limit));
    stat.div_done   = div_done;
    stat.sqrt_done  = sqrt_done;
    stat.out_free   = out_free;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      relax     <= RELAX_RESET;
      cons_dist <= DIST_RESET;
      source    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RELAX:  relax     <= cfg_data[RELAX_W-1:0];
        CFG_DIST:   cons_dist <= cfg_data[RADIUS_W-1:0];
        CFG_SOURCE: source    <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // point state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        orig[i] <= '0;
        cur[i]  <= '0;
        nsum[i] <= '0;
      end
      count     <= '0;
      limit     <= '0;
      run_max   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result beat may load in the cycle the old one leaves
      if (ctl.op == OP_FIN_PIN || ctl.op == OP_FIN_OUT) out_valid <= 1'b1;
      else if (!out_stall)                              out_valid <= 1'b0;
      case (ctl.op)
        OP_LOAD_ORIG: begin
          for (int i = 0; i < 3; i++) begin
            orig[i] <= in_pos[i];
            nsum[i] <= '0;
          end
          count <= '0;
          limit <= (r_sel == '1) ? '1 : mul_p;
        end
        OP_LOAD_CUR: begin
          for (int i = 0; i < 3; i++) cur[i] <= in_pos[i];
        end
        OP_ADD_NB: begin
          if (count < CW'(MAX_NEIGHBORS)) begin
            for (int i = 0; i < 3; i++)
              nsum[i] <= nsum[i] + {{(SW-COORD_W){in_pos[i][COORD_W-1]}}, in_pos[i]};
            count <= count + 1'b1;
          end
        end
        OP_CLR_MAX: run_max <= '0;
        OP_FIN_PIN: begin
          new_x        <= orig[0];
          new_y        <= orig[1];
          new_z        <= orig[2];
          moved_sq     <= '0;
          max_moved_sq <= run_max;
          pinned       <= 1'b1;
          for (int i = 0; i < 3; i++) nsum[i] <= '0;
          count <= '0;
        end
        OP_FIN_OUT: begin
          new_x        <= xpos[0];
          new_y        <= xpos[1];
          new_z        <= xpos[2];
          moved_sq     <= moved;
          max_moved_sq <= (moved > run_max) ? moved : run_max;
          run_max      <= (moved > run_max) ? moved : run_max;
          pinned       <= 1'b0;
          for (int i = 0; i < 3; i++) nsum[i] <= '0;
          count <= '0;
        end
        default: ;
      endcase
    end
  end

  // finish working registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_AVG_START: avg_neg <= avg_num[AVG_NW-1];
      OP_AVG_SAVE:  diff_reg <= {avg[32], avg} - {{2{cur[ctl.idx][31]}}, cur[ctl.idx]};
      OP_RELAX_MUL: relax_prod <= diff_reg * $signed({1'b0, relax});
      OP_STEP:      xpos[ctl.idx] <= vsat;
      OP_DIFF_ORIG, OP_DIFF_CUR: begin
        mag_reg <= dmag;
        neg_reg <= dsub[32];
        if (ctl.idx == 2'd0) acc <= '0;
      end
      OP_SQ_MUL, OP_SCALE_MUL: prod_reg <= mul_p;
      OP_ACC_ADD:   acc <= acc + ACC_W'(prod_reg);
      OP_SAVE_R:    r_reg <= sqrt_root[COORD_W-1:0];
      OP_SAVE_LEN:  len_reg <= sqrt_root[LEN_W-1:0];
      OP_CLAMP_SET: xpos[ctl.idx] <= neg_reg ? (orig[ctl.idx] - qv) : (orig[ctl.idx] + qv);
      default: ;
    endcase
  end

endmodule

// File: tb/constrained_laplacian_point_update_test.sv
`timescale 1ns / 100ps

module constrained_laplacian_point_update_test;
  import clpu_pkg::*;

  localparam int  LIMIT_CYCLES = 4000000;
  localparam int  DRAIN_CYCLES = 600;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;
  localparam logic [CMD_W-1:0] CMD_UNUSED5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

  typedef struct {
    logic [31:0] x, y, z;
    logic [63:0] moved, max_moved;
    logic        pin;
  } smooth_result_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [CMD_W-1:0] command = '0;
  logic [31:0] coord_x = '0, coord_y = '0, coord_z = '0, point_constraint = '0;
  logic out_valid, out_stall = 0;
  logic [31:0] new_x, new_y, new_z;
  logic [63:0] moved_sq, max_moved_sq;
  logic pinned;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  constrained_laplacian_point_update u_top (.*);

  // shadow state of the smoothing datapath
  logic [16:0] m_relax;
  logic [31:0] m_dist;
  logic        m_src;
  longint      m_orig [3];
  longint      m_cur [3];
  longint      m_nsum [3];
  int          m_ncount;
  logic [63:0] m_limit_sq;
  logic [63:0] m_run_max;

  smooth_result_t smoothed_q [$];
  int errors = 0;
  int beats_sent = 0;
  int gap_pct = 0, stall_pct = 0;
  int cycles = 0;

  initial forever #2 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] dist2(longint a0, longint a1, longint a2,
                                         longint b0, longint b1, longint b2);
    logic [127:0] m0, m1, m2;
    m0 = {64'b0, mag64(a0 - b0)};
    m1 = {64'b0, mag64(a1 - b1)};
    m2 = {64'b0, mag64(a2 - b2)};
    return m0 * m0 + m1 * m1 + m2 * m2;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [127:0] res, c;
    res = 0;
    for (int b = 33; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= v) res = c;
    end
    return res[63:0];
  endfunction

  function automatic void clear_stencil();
    for (int i = 0; i < 3; i++) m_nsum[i] = 0;
    m_ncount = 0;
  endfunction

  // apply one accepted command to the shadow state, queue any result
  function automatic void update_point(logic [CMD_W-1:0] cmd, logic [31:0] cx,
                                       logic [31:0] cy, logic [31:0] cz,
                                       logic [31:0] pc);
    longint p [3];
    longint x [3];
    longint n, avg, stp, v, d;
    logic [31:0] r32;
    logic [127:0] d2, mv;
    logic [63:0] r, len, m, moved;
    smooth_result_t e;
    p[0] = longint'($signed(cx));
    p[1] = longint'($signed(cy));
    p[2] = longint'($signed(cz));
    case (cmd)
      CMD_LOAD_ORIG: begin
        r32 = m_src ? pc : m_dist;
        for (int i = 0; i < 3; i++) m_orig[i] = p[i];
        m_limit_sq = (r32 == ALL_ONES32) ? '1 : {32'b0, r32} * {32'b0, r32};
        clear_stencil();
      end
      CMD_LOAD_CUR: for (int i = 0; i < 3; i++) m_cur[i] = p[i];
      CMD_ADD_NB: begin
        if (m_ncount < DEF_MAX_NEIGHBORS) begin
          for (int i = 0; i < 3; i++) m_nsum[i] += p[i];
          m_ncount++;
        end
      end
      CMD_CLR_MAX: m_run_max = 0;
      CMD_FINISH: begin
        if (m_ncount == 0 || m_limit_sq == 0) begin
          e.x = m_orig[0][31:0];
          e.y = m_orig[1][31:0];
          e.z = m_orig[2][31:0];
          e.moved = 0;
          e.max_moved = m_run_max;
          e.pin = 1;
        end else begin
          n = m_ncount;
          for (int i = 0; i < 3; i++) begin
            avg = floor_div(2 * m_nsum[i] + n, 2 * n);
            stp = floor_div((avg - m_cur[i]) * longint'(m_relax) + 32768, 65536);
            v = m_cur[i] + stp;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            x[i] = v;
          end
          // pull back onto the constraint sphere
          if (m_limit_sq != '1) begin
            d2 = dist2(x[0], x[1], x[2], m_orig[0], m_orig[1], m_orig[2]);
            if (d2 > {64'b0, m_limit_sq}) begin
              r = isqrt({64'b0, m_limit_sq});
              len = isqrt(d2);
              for (int i = 0; i < 3; i++) begin
                d = x[i] - m_orig[i];
                m = (mag64(d) * r) / len;
                x[i] = d < 0 ? m_orig[i] - longint'(m) : m_orig[i] + longint'(m);
              end
            end
          end
          mv = dist2(x[0], x[1], x[2], m_cur[0], m_cur[1], m_cur[2]);
          moved = (mv[127:64] != 0) ? '1 : mv[63:0];
          if (moved > m_run_max) m_run_max = moved;
          e.x = x[0][31:0];
          e.y = x[1][31:0];
          e.z = x[2][31:0];
          e.moved = moved;
          e.max_moved = m_run_max;
          e.pin = 0;
        end
        smoothed_q.push_back(e);
        clear_stencil();
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    smooth_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (smoothed_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = smoothed_q.pop_front();
        if (new_x !== e.x) begin
          $error("new_x exp %h got %h", e.x, new_x); errors++;
        end
        if (new_y !== e.y) begin
          $error("new_y exp %h got %h", e.y, new_y); errors++;
        end
        if (new_z !== e.z) begin
          $error("new_z exp %h got %h", e.z, new_z); errors++;
        end
        if (moved_sq !== e.moved) begin
          $error("moved_sq exp %h got %h", e.moved, moved_sq); errors++;
        end
        if (max_moved_sq !== e.max_moved) begin
          $error("max_moved_sq exp %h got %h", e.max_moved, max_moved_sq); errors++;
        end
        if (pinned !== e.pin) begin
          $error("pinned exp %b got %b", e.pin, pinned); errors++;
        end
      end
    end
  end

  // send one beat; called right after a rising edge
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] cz, logic [31:0] pc);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    coord_x <= cx;
    coord_y <= cy;
    coord_z <= cz;
    point_constraint <= pc;
    do @(posedge clk); while (in_stall);
    update_point(cmd, cx, cy, cz, pc);
    beats_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one write, then the enable drops before the next write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_RELAX:  m_relax = val[16:0];
      CFG_DIST:   m_dist = val;
      CFG_SOURCE: m_src = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [16:0] relax, logic [31:0] radius, logic src);
    stop_sending();
    drain();
    write_reg(CFG_RELAX, {15'b0, relax});
    write_reg(CFG_DIST, radius);
    write_reg(CFG_SOURCE, {31'b0, src});
  endtask

  function automatic logic [31:0] any32();
    case ($urandom_range(5))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return ALL_ONES32;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near(logic [31:0] c, int sh);
    if ($urandom_range(19) == 0) return any32();
    return c + ($urandom & ((32'd1 << sh) - 1)) - (32'd1 << (sh - 1));
  endfunction

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(7))
      0: return 0;
      1: return ALL_ONES32;
      2: return $urandom;
      default: return $urandom & ((32'd1 << $urandom_range(1, 31)) - 1);
    endcase
  endfunction

  // one well-formed point with random content, sometimes broken or noisy
  task automatic random_point();
    logic [31:0] c;
    int sh, nb;
    c = ($urandom_range(3) == 0) ? any32() : $urandom;
    sh = $urandom_range(2, 31);
    if ($urandom_range(9) != 0)
      send_beat(CMD_LOAD_ORIG, near(c, sh), near(c, sh), near(c, sh), pick_radius());
    if ($urandom_range(9) != 0)
      send_beat(CMD_LOAD_CUR, near(c, sh), near(c, sh), near(c, sh), $urandom);
    case ($urandom_range(19))
      0: nb = 0;
      1: nb = $urandom_range(60, 70);
      default: nb = $urandom_range(1, 8);
    endcase
    for (int i = 0; i < nb; i++) begin
      if ($urandom_range(29) == 0)
        send_beat(CMD_CLR_MAX, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(49) == 0)
        send_beat(3'($urandom_range(CMD_UNUSED5, CMD_UNUSED7)), $urandom, $urandom,
                  $urandom, $urandom);
      send_beat(CMD_ADD_NB, near(c, sh), near(c, sh), near(c, sh), $urandom);
    end
    if ($urandom_range(19) != 0)
      send_beat(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic random_run(int beats);
    int stop_at;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) random_point();
  endtask

  // directed corners under the reset register values, then extremes
  task automatic test_directed();
    send_beat(CMD_FINISH, 0, 0, 0, 0);                      // empty stencil
    send_beat(CMD_LOAD_ORIG, MAX_POS, MIN_NEG, 0, ALL_ONES32);
    send_beat(CMD_LOAD_CUR, MIN_NEG, MAX_POS, ALL_ONES32, 0);
    send_beat(CMD_ADD_NB, MAX_POS, MAX_POS, MAX_POS, 0);
    send_beat(CMD_ADD_NB, MIN_NEG, MIN_NEG, MIN_NEG, 0);
    send_beat(CMD_FINISH, 0, 0, 0, 0);
    send_beat(CMD_UNUSED5, 1, 2, 3, 4);
    send_beat(CMD_UNUSED7, 1, 2, 3, 4);
    send_beat(CMD_CLR_MAX, 0, 0, 0, 0);
    set_regs(17'd65536, ALL_ONES32, 1'b1);                  // no clamping
    send_beat(CMD_LOAD_ORIG, 0, 0, 0, ALL_ONES32);
    send_beat(CMD_LOAD_CUR, MIN_NEG, MIN_NEG, MIN_NEG, 0);
    send_beat(CMD_ADD_NB, MAX_POS, MAX_POS, MAX_POS, 0);
    send_beat(CMD_FINISH, 0, 0, 0, 0);                      // saturating move
    send_beat(CMD_LOAD_ORIG, 0, 0, 0, 0);                   // zero constraint
    send_beat(CMD_ADD_NB, 5, 6, 7, 0);
    send_beat(CMD_FINISH, 0, 0, 0, 0);
    send_beat(CMD_LOAD_ORIG, 32'h0001_0000, 0, 0, 32'h0000_8000);
    send_beat(CMD_LOAD_CUR, 0, 0, 0, 0);
    send_beat(CMD_ADD_NB, 32'h0100_0000, 32'h0080_0000, MIN_NEG, 0);
    send_beat(CMD_ADD_NB, 32'h0100_0000, 32'h0080_0000, 3, 0);
    send_beat(CMD_FINISH, 0, 0, 0, 0);                      // clamped
    send_beat(CMD_CLR_MAX, 0, 0, 0, 0);
  endtask

  task automatic test_reg_sweep();
    set_regs(17'd0, 32'd0, 1'b0);
    random_run(80);
    set_regs(17'd32768, ALL_ONES32, 1'b0);
    random_run(80);
    set_regs(17'($urandom_range(0, 65536)), $urandom, 1'b0);
    random_run(80);
    set_regs(17'd65536, 32'h0000_FFFF, 1'b1);
    random_run(100);
  endtask

  task automatic test_idle_phases();
    gap_pct = 48; stall_pct = 0;
    set_regs(17'($urandom_range(0, 65536)), $urandom >> $urandom_range(31), 1'b1);
    random_run(220);
    gap_pct = 0; stall_pct = 48;
    set_regs(17'd655, 32'd66, 1'b0);
    random_run(220);
    gap_pct = 6; stall_pct = 6;
    set_regs(17'($urandom_range(0, 65536)), $urandom, 1'b1);
    random_run(220);
    gap_pct = 0; stall_pct = 0;
    random_run(220);
  endtask

  initial begin
    m_relax = RELAX_RESET;
    m_dist = DIST_RESET;
    m_src = 0;
    for (int i = 0; i < 3; i++) begin
      m_orig[i] = 0;
      m_cur[i] = 0;
    end
    clear_stencil();
    m_limit_sq = 0;
    m_run_max = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_reg_sweep();
    test_idle_phases();
    stop_sending();
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
